[src/avpi_pkg.sv]
package avpi_pkg;

   // Field and register widths
   localparam int ADC_W      = 12;
   localparam int DUTY_W     = 10;
   localparam int GAIN_W     = 16;
   localparam int VCFG_W     = 18;
   localparam int SUM_W      = 17;
   localparam int FRAC_W     = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 18;

   localparam int DEF_SAMPLES_PER_UPDATE = 20;
   localparam int QUEUE_DEPTH            = 2;

   // Average to volts: sum * 264 / (5 * samples) is avg * 3.3 / 4096 in Q2.16
   localparam int VOLT_SCALE_NUM = 264;
   localparam int VOLT_SCALE_DEN = 5;
   localparam int X_W            = 26;
   localparam int RECIP_SHIFT    = 26;
   localparam int VOLT_W         = 24;
   localparam int ERR_W          = VOLT_W + 1;
   localparam int MAG_W          = 24;
   localparam int PROD_W         = MAG_W + GAIN_W;
   localparam int TERM_W         = 32;
   localparam int ACC_W          = TERM_W + 2;
   localparam int INTEG_W        = DUTY_W + FRAC_W;
   localparam int KP_SHIFT       = 12;
   localparam int KI_SHIFT       = 8;
   localparam int ONE_COUNT      = 1 << FRAC_W;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_KP_GAIN        = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_KI_GAIN        = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SETPOINT_VOLTS = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_OV_LIMIT       = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_INTEG_MAX      = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_DUTY_FOLD_HIGH = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_DUTY_FOLD_LOW  = 3'd6;

   // Register reset values
   localparam logic [GAIN_W-1:0] RST_KP_GAIN        = 16'd2458;
   localparam logic [GAIN_W-1:0] RST_KI_GAIN        = 16'd5120;
   localparam logic [VCFG_W-1:0] RST_SETPOINT_VOLTS = 18'd65536;
   localparam logic [VCFG_W-1:0] RST_OV_LIMIT       = 18'd196608;
   localparam logic [DUTY_W-1:0] RST_INTEG_MAX      = 10'd300;
   localparam logic [DUTY_W-1:0] RST_DUTY_FOLD_HIGH = 10'd280;
   localparam logic [DUTY_W-1:0] RST_DUTY_FOLD_LOW  = 10'd20;

   typedef struct packed {
      logic [GAIN_W-1:0] kp_gain;
      logic [GAIN_W-1:0] ki_gain;
      logic [VCFG_W-1:0] setpoint_volts;
      logic [VCFG_W-1:0] ov_limit;
      logic [DUTY_W-1:0] integ_max;
      logic [DUTY_W-1:0] duty_fold_high;
      logic [DUTY_W-1:0] duty_fold_low;
   } cfg_type;

   typedef struct packed {
      logic             valid;
      logic [SUM_W-1:0] sum;
   } push_type;

   typedef struct packed {
      logic             valid;
      logic             full;
      logic [SUM_W-1:0] sum;
   } head_type;

endpackage

[src/avpi_channels.sv]
interface avpi_req_if;
   import avpi_pkg::*;

   logic             valid;
   logic             ready;
   logic [ADC_W-1:0] adc_sample;

   modport source (output valid, output adc_sample, input ready);
   modport sink (input valid, input adc_sample, output ready);
endinterface

interface avpi_rsp_if;
   import avpi_pkg::*;

   logic              valid;
   logic              ready;
   logic [DUTY_W-1:0] duty_count;
   logic              overvoltage;

   modport source (output valid, output duty_count, output overvoltage, input ready);
   modport sink (input valid, input duty_count, input overvoltage, output ready);
endinterface

[src/avpi_front.sv]
module avpi_front #(
   parameter int SAMPLES_PER_UPDATE = avpi_pkg::DEF_SAMPLES_PER_UPDATE
) (
   input  logic               clock,
   input  logic               reset,
   avpi_req_if.sink           req_bus,
   input  logic               queue_full,
   output avpi_pkg::push_type push
);
   import avpi_pkg::*;

   localparam int IDX_W = (SAMPLES_PER_UPDATE > 1) ? $clog2(SAMPLES_PER_UPDATE) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES_PER_UPDATE - 1);

   logic [SUM_W-1:0] sum_ff, sum_in, sum_next;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             accept, last;

   assign req_bus.ready = !queue_full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign sum_next      = sum_ff + SUM_W'(req_bus.adc_sample);
   assign last          = (idx_ff >= LAST_IDX);

   // The transaction that closes a block hands its full sum to the queue.
   assign push.valid = accept && last;
   assign push.sum   = sum_next;

   always_comb begin
      sum_in = sum_ff;
      idx_in = idx_ff;
      if (accept) begin
         if (last) begin
            sum_in = '0;
            idx_in = '0;
         end else begin
            sum_in = sum_next;
            idx_in = idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         idx_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         idx_ff <= idx_in;
      end
   end

endmodule

[src/avpi_queue.sv]
module avpi_queue (
   input  logic               clock,
   input  logic               reset,
   input  avpi_pkg::push_type push,
   input  logic               pop,
   output avpi_pkg::head_type head
);
   import avpi_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   logic [SUM_W-1:0] mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign head.valid = (count_ff != '0);
   assign head.full  = (count_ff == FULL_CNT);
   assign head.sum   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(push.valid) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[src/avpi_back.sv]
module avpi_back #(
   parameter int SAMPLES_PER_UPDATE = avpi_pkg::DEF_SAMPLES_PER_UPDATE
) (
   input  logic               clock,
   input  logic               reset,
   input  avpi_pkg::cfg_type  cfg,
   input  avpi_pkg::head_type head,
   output logic               pop,
   avpi_rsp_if.source         rsp_bus
);
   import avpi_pkg::*;

   localparam int DIVISOR = VOLT_SCALE_DEN * SAMPLES_PER_UPDATE;
   localparam logic [RECIP_SHIFT-1:0] RECIP = RECIP_SHIFT'((2 ** RECIP_SHIFT) / DIVISOR);
   localparam int RP_W = X_W + RECIP_SHIFT;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_MUL,
      ST_DIV_FIX,
      ST_ERR,
      ST_GAIN,
      ST_INTEG,
      ST_OUTPUT
   } state_type;

   state_type state_ff;

   logic [X_W-1:0]           x_ff, x_in;
   logic [VOLT_W-1:0]        q0_ff, q0_in;
   logic [VOLT_W-1:0]        volts_ff, volts_in;
   logic                     err_neg_ff, err_neg_in;
   logic [MAG_W-1:0]         err_mag_ff, err_mag_in;
   logic                     over_ff, over_in;
   logic [PROD_W-1:0]        p_prod_ff, p_prod_in;
   logic [PROD_W-1:0]        i_prod_ff, i_prod_in;
   logic signed [TERM_W-1:0] p_term_ff, p_term_in;
   logic signed [TERM_W-1:0] prev_term_ff, i_term_in;
   logic [INTEG_W-1:0]       integ_ff, integ_in;
   logic                     rsp_valid_ff;
   logic [DUTY_W-1:0]        duty_ff, duty_in;
   logic                     rsp_over_ff;

   logic [RP_W-1:0]          recip_prod;
   logic [X_W-1:0]           rem;
   logic signed [ERR_W-1:0]  err_s;
   logic [INTEG_W-1:0]       top_val;
   logic signed [ACC_W-1:0]  top_s, acc, outv, one_s;
   logic                     hi, low_fold;

   // Magnitude times gain comes in already shifted; cap it so the signed
   // term stays inside 32 bits, then apply the sign.
   function automatic logic signed [TERM_W-1:0] sat_term(input logic neg,
                                                         input logic [PROD_W-1:0] mag);
      logic [PROD_W-1:0] lim;
      logic [PROD_W-1:0] capped;
      lim    = neg ? (PROD_W'(1) << (TERM_W - 1))
                   : ((PROD_W'(1) << (TERM_W - 1)) - PROD_W'(1));
      capped = (mag > lim) ? lim : mag;
      sat_term = neg ? $signed(TERM_W'(-capped)) : $signed(TERM_W'(capped));
   endfunction

   assign pop = (state_ff == ST_IDLE) && head.valid;

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.duty_count  = duty_ff;
   assign rsp_bus.overvoltage = rsp_over_ff;

   always_comb begin
      // Division by the block constant: reciprocal estimate, then one correction.
      x_in       = X_W'(head.sum) * X_W'(VOLT_SCALE_NUM);
      recip_prod = RP_W'(x_ff) * RP_W'(RECIP);
      q0_in      = recip_prod[RECIP_SHIFT +: VOLT_W];
      rem        = x_ff - X_W'(q0_ff) * X_W'(DIVISOR);
      volts_in   = q0_ff + VOLT_W'(rem >= X_W'(DIVISOR));

      err_s      = $signed(ERR_W'(cfg.setpoint_volts)) - $signed(ERR_W'(volts_ff));
      err_neg_in = err_s[ERR_W-1];
      err_mag_in = err_neg_in ? MAG_W'(-err_s) : MAG_W'(err_s);
      over_in    = volts_ff > VOLT_W'(cfg.ov_limit);

      p_prod_in  = PROD_W'(err_mag_ff) * PROD_W'(cfg.kp_gain);
      i_prod_in  = PROD_W'(err_mag_ff) * PROD_W'(cfg.ki_gain);

      p_term_in  = sat_term(err_neg_ff, p_prod_ff >> KP_SHIFT);
      i_term_in  = sat_term(err_neg_ff, i_prod_ff >> KI_SHIFT);

      top_val    = {cfg.integ_max, {FRAC_W{1'b0}}};
      top_s      = $signed(ACC_W'(top_val));
      acc        = $signed(ACC_W'(integ_ff)) + ACC_W'(i_term_in) + ACC_W'(prev_term_ff);
      priority if (acc >= top_s) begin
         integ_in = top_val;
      end else if (acc <= 0) begin
         integ_in = '0;
      end else begin
         integ_in = acc[INTEG_W-1:0];
      end

      one_s      = $signed(ACC_W'(ONE_COUNT));
      outv       = ACC_W'(p_term_ff) + $signed(ACC_W'(integ_ff));
      hi         = (outv >= top_s);
      low_fold   = hi ? (cfg.duty_fold_high <= DUTY_W'(1)) : (outv <= one_s);
      priority if (over_ff || low_fold) begin
         duty_in = cfg.duty_fold_low;
      end else if (hi) begin
         duty_in = cfg.duty_fold_high;
      end else begin
         duty_in = outv[FRAC_W +: DUTY_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         integ_ff     <= '0;
         prev_term_ff <= '0;
      end else begin
         // In the output state the valid flag is reloaded below instead.
         if (rsp_bus.valid && rsp_bus.ready && (state_ff != ST_OUTPUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (head.valid) begin
                  x_ff     <= x_in;
                  state_ff <= ST_DIV_MUL;
               end
            end
            ST_DIV_MUL: begin
               q0_ff    <= q0_in;
               state_ff <= ST_DIV_FIX;
            end
            ST_DIV_FIX: begin
               volts_ff <= volts_in;
               state_ff <= ST_ERR;
            end
            ST_ERR: begin
               err_neg_ff <= err_neg_in;
               err_mag_ff <= err_mag_in;
               over_ff    <= over_in;
               state_ff   <= ST_GAIN;
            end
            ST_GAIN: begin
               p_prod_ff <= p_prod_in;
               i_prod_ff <= i_prod_in;
               state_ff  <= ST_INTEG;
            end
            ST_INTEG: begin
               integ_ff     <= integ_in;
               prev_term_ff <= i_term_in;
               p_term_ff    <= p_term_in;
               state_ff     <= ST_OUTPUT;
            end
            ST_OUTPUT: begin
               // Hold here while the previous transaction is still unclaimed.
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  rsp_valid_ff <= 1'b1;
                  duty_ff      <= duty_in;
                  rsp_over_ff  <= over_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

[src/averaged_pi_duty_controller_core.sv]
// Throughput: one sample per cycle while the queue is not full; one result per block of
// SAMPLES_PER_UPDATE samples. The last sample of a block pushes the block sum into the queue; the
// back-end sequencer (reciprocal division, gain multipliers, integrator) takes a new sum only when idle.
// A two-entry queue of block sums lets sampling continue while a result waits to be taken.
// Reset is synchronous and active high: registers return to their defaults, the sum, index,
// integrator, queue and pending result are cleared.
module averaged_pi_duty_controller_core #(
   parameter int SAMPLES_PER_UPDATE = avpi_pkg::DEF_SAMPLES_PER_UPDATE
) (
   input  logic                            clock,
   input  logic                            reset,
   avpi_req_if.sink                        req_bus,
   avpi_rsp_if.source                      rsp_bus,
   input  logic                            csr_wr_en,
   input  logic [avpi_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [avpi_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import avpi_pkg::*;

   cfg_type  cfg_ff;
   push_type push;
   head_type head;
   logic     pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp_gain        <= RST_KP_GAIN;
         cfg_ff.ki_gain        <= RST_KI_GAIN;
         cfg_ff.setpoint_volts <= RST_SETPOINT_VOLTS;
         cfg_ff.ov_limit       <= RST_OV_LIMIT;
         cfg_ff.integ_max      <= RST_INTEG_MAX;
         cfg_ff.duty_fold_high <= RST_DUTY_FOLD_HIGH;
         cfg_ff.duty_fold_low  <= RST_DUTY_FOLD_LOW;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_KP_GAIN:        cfg_ff.kp_gain        <= csr_wdata[GAIN_W-1:0];
            CSR_KI_GAIN:        cfg_ff.ki_gain        <= csr_wdata[GAIN_W-1:0];
            CSR_SETPOINT_VOLTS: cfg_ff.setpoint_volts <= csr_wdata[VCFG_W-1:0];
            CSR_OV_LIMIT:       cfg_ff.ov_limit       <= csr_wdata[VCFG_W-1:0];
            CSR_INTEG_MAX:      cfg_ff.integ_max      <= csr_wdata[DUTY_W-1:0];
            CSR_DUTY_FOLD_HIGH: cfg_ff.duty_fold_high <= csr_wdata[DUTY_W-1:0];
            CSR_DUTY_FOLD_LOW:  cfg_ff.duty_fold_low  <= csr_wdata[DUTY_W-1:0];
            default: begin
            end
         endcase
      end
   end

   avpi_front #(
      .SAMPLES_PER_UPDATE(SAMPLES_PER_UPDATE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .queue_full (head.full),
      .push       (push)
   );

   avpi_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head)
   );

   avpi_back #(
      .SAMPLES_PER_UPDATE(SAMPLES_PER_UPDATE)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .head    (head),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

   // A completed block must never be offered to a full queue.
   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !head.full)
      else $error("block sum pushed into a full queue");

   // The back end only takes a block sum that is actually queued.
   a_pop_has_data: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("queue popped while empty");

   // No stale result survives a reset.
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("result transaction offered straight after reset");

endmodule
